[rtl/hhfp_pkg.sv]
// Shared types and constants for the HTTP header field parser.
// Holds the parse phase and byte class codes and the queue entry layout.
// No dependencies; every other file in rtl/ refers to this package.
package hhfp_pkg;

	// Field widths fixed by the interface.
	localparam int DATA_W = 8;
	localparam int LEN_W  = 13;

	// Queue between the classifier and the phase tracker.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Character codes used by the classifier.
	localparam logic [DATA_W-1:0] CHAR_TAB   = 8'h09;
	localparam logic [DATA_W-1:0] CHAR_LF    = 8'h0A;
	localparam logic [DATA_W-1:0] CHAR_CR    = 8'h0D;
	localparam logic [DATA_W-1:0] CTL_LAST   = 8'd31;
	localparam logic [DATA_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [DATA_W-1:0] CHAR_COLON = 8'h3A;
	localparam logic [DATA_W-1:0] CHAR_DEL   = 8'd127;

	// Where the parser stands within the current header line.
	typedef enum logic [2:0] {
		PH_LINE,
		PH_KEY,
		PH_KEYWS,
		PH_PREVAL,
		PH_VALUE,
		PH_VALLF,
		PH_ENDLF,
		PH_ERROR
	} phase_t;

	// Tag attached to each result item.
	typedef enum logic [2:0] {
		CL_SKIP,
		CL_KEY,
		CL_VALUE,
		CL_LINE,
		CL_BLOCK,
		CL_ERROR,
		CL_AFTER
	} byte_class_t;

	// One classified byte as it waits in the queue.
	typedef struct packed {
		logic [DATA_W-1:0] data_byte;
		logic              first_byte;
		logic              last_byte;
		logic              is_ws;
		logic              is_ctl;
		logic              is_sep;
		logic              is_cr;
		logic              is_lf;
		logic              is_colon;
	} entry_t;

endpackage

[rtl/hhfp_if.sv]
// Valid/ready channel interfaces for the HTTP header field parser.
// Input channel carries raw bytes, output channel carries tagged bytes.
// Depends on hhfp_pkg for field widths.
interface hhfp_in_if;
	logic                        valid;
	logic                        ready;
	logic [hhfp_pkg::DATA_W-1:0] data_byte;
	logic                        first_byte;
	logic                        last_byte;

	modport source (output valid, output data_byte, output first_byte, output last_byte,
		input ready);
	modport sink (input valid, input data_byte, input first_byte, input last_byte,
		output ready);
endinterface

interface hhfp_out_if;
	logic                        valid;
	logic                        ready;
	logic [2:0]                  byte_class;
	logic [hhfp_pkg::DATA_W-1:0] data_out;
	logic [hhfp_pkg::LEN_W-1:0]  value_length;

	modport source (output valid, output byte_class, output data_out, output value_length,
		input ready);
	modport sink (input valid, input byte_class, input data_out, input value_length,
		output ready);
endinterface

[rtl/hhfp_front.sv]
// Front end of the HTTP header field parser: accepts raw bytes and classifies them.
// Each accepted item is pushed into the queue with its character class flags.
// Depends on hhfp_pkg and hhfp_in_if.
module hhfp_front (
	hhfp_in_if.sink          raw,
	input  logic             full,
	output logic             push,
	output hhfp_pkg::entry_t entry
);

	logic [hhfp_pkg::DATA_W-1:0] c;
	logic                        ws;
	logic                        punct;

	assign c = raw.data_byte;

	// Accept whenever the queue has room.
	assign raw.ready = !full;
	assign push      = raw.valid && !full;

	// Whitespace is tab through carriage return, and space.
	assign ws = (c == hhfp_pkg::CHAR_SPACE) ||
		((c >= hhfp_pkg::CHAR_TAB) && (c <= hhfp_pkg::CHAR_CR));

	// Token separators other than whitespace.
	assign punct = (c == "(") || (c == ")") || (c == "<") || (c == ">") || (c == "@") ||
		(c == ",") || (c == ";") || (c == hhfp_pkg::CHAR_COLON) || (c == "\\") ||
		(c == "\"") || (c == "/") || (c == "[") || (c == "]") || (c == "?") ||
		(c == "=") || (c == "{") || (c == "}");

	// Build the queue entry.
	always_comb begin
		entry.data_byte  = c;
		entry.first_byte = raw.first_byte;
		entry.last_byte  = raw.last_byte;
		entry.is_ws      = ws;
		entry.is_ctl     = (c <= hhfp_pkg::CTL_LAST) || (c == hhfp_pkg::CHAR_DEL);
		entry.is_sep     = punct || ws;
		entry.is_cr      = (c == hhfp_pkg::CHAR_CR);
		entry.is_lf      = (c == hhfp_pkg::CHAR_LF);
		entry.is_colon   = (c == hhfp_pkg::CHAR_COLON);
	end

endmodule

[rtl/hhfp_queue.sv]
// Short FIFO between the classifier and the phase tracker of the header parser.
// Lets either side stall without stalling the other.
// Depends on hhfp_pkg for the entry type and depth.
module hhfp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  hhfp_pkg::entry_t push_entry,
	output logic             full,
	input  logic             pop,
	output hhfp_pkg::entry_t pop_entry,
	output logic             avail
);

	hhfp_pkg::entry_t                  slots_q [hhfp_pkg::QUEUE_DEPTH];
	logic [hhfp_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [hhfp_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [hhfp_pkg::QCNT_W-1:0]       count_q;

	assign full      = (count_q == hhfp_pkg::QCNT_W'(hhfp_pkg::QUEUE_DEPTH));
	assign avail     = (count_q != '0);
	assign pop_entry = slots_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + hhfp_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + hhfp_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + hhfp_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - hhfp_pkg::QCNT_W'(1);
			end
		end
	end

	// Entry storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

[rtl/hhfp_back.sv]
// Back end of the HTTP header field parser: tracks the line phase and value length.
// Loads one classified item per cycle from the queue while the output register is free or draining.
// Depends on hhfp_pkg and hhfp_out_if.
module hhfp_back #(
	parameter int MAX_VALUE_LEN = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             avail,
	input  hhfp_pkg::entry_t entry,
	output logic             pop,
	hhfp_out_if.source       classified
);

	localparam int CNT_W = $clog2(MAX_VALUE_LEN + 1);

	hhfp_pkg::phase_t              phase_q;
	logic                          finished_q;
	logic [CNT_W-1:0]              value_count_q;
	logic [CNT_W-1:0]              trimmed_count_q;

	hhfp_pkg::phase_t              cur_phase;
	logic                          cur_fin;
	logic [CNT_W-1:0]              cur_vc;
	logic [CNT_W-1:0]              cur_tc;
	logic [CNT_W-1:0]              add_base_vc;
	logic [CNT_W-1:0]              add_base_tc;
	logic [CNT_W-1:0]              add_vc;
	logic [CNT_W-1:0]              add_tc;

	hhfp_pkg::phase_t              nxt_phase;
	logic                          nxt_fin;
	logic [CNT_W-1:0]              nxt_vc;
	logic [CNT_W-1:0]              nxt_tc;
	hhfp_pkg::byte_class_t         nxt_class;
	logic [hhfp_pkg::LEN_W-1:0]    nxt_len;

	logic                          out_valid_q;
	hhfp_pkg::byte_class_t         out_class_q;
	logic [hhfp_pkg::DATA_W-1:0]   out_data_q;
	logic [hhfp_pkg::LEN_W-1:0]    out_len_q;

	// Take the next item whenever the output register is free or being emptied.
	assign pop = avail && (!out_valid_q || classified.ready);

	// A restart byte sees the reset state.
	always_comb begin
		cur_phase = entry.first_byte ? hhfp_pkg::PH_LINE : phase_q;
		cur_fin   = entry.first_byte ? 1'b0 : finished_q;
		cur_vc    = entry.first_byte ? '0 : value_count_q;
		cur_tc    = entry.first_byte ? '0 : trimmed_count_q;
	end

	// Value byte counting: the first value byte starts from zero, the count saturates,
	// and the trimmed length follows the count at every non-whitespace byte.
	always_comb begin
		add_base_vc = (cur_phase == hhfp_pkg::PH_PREVAL) ? '0 : cur_vc;
		add_base_tc = (cur_phase == hhfp_pkg::PH_PREVAL) ? '0 : cur_tc;
		add_vc      = (add_base_vc < CNT_W'(MAX_VALUE_LEN)) ?
			add_base_vc + CNT_W'(1) : add_base_vc;
		add_tc      = entry.is_ws ? add_base_tc : add_vc;
	end

	// Phase transitions and the tag of the current byte.
	always_comb begin
		nxt_phase = cur_phase;
		nxt_fin   = cur_fin;
		nxt_vc    = cur_vc;
		nxt_tc    = cur_tc;
		nxt_class = hhfp_pkg::CL_SKIP;
		nxt_len   = '0;
		if (cur_fin) begin
			nxt_class = hhfp_pkg::CL_AFTER;
		end else begin
			unique case (cur_phase)
				hhfp_pkg::PH_LINE: begin
					if (entry.is_cr) begin
						nxt_phase = hhfp_pkg::PH_ENDLF;
					end else if (entry.is_ctl) begin
						nxt_phase = hhfp_pkg::PH_ERROR;
					end else if (!entry.is_ws) begin
						if (entry.is_sep) begin
							nxt_phase = hhfp_pkg::PH_ERROR;
						end else begin
							nxt_phase = hhfp_pkg::PH_KEY;
							nxt_class = hhfp_pkg::CL_KEY;
						end
					end
				end
				hhfp_pkg::PH_KEY: begin
					if (entry.is_ws) begin
						nxt_phase = hhfp_pkg::PH_KEYWS;
					end else if (entry.is_colon) begin
						nxt_phase = hhfp_pkg::PH_PREVAL;
					end else if (entry.is_ctl || entry.is_sep) begin
						nxt_phase = hhfp_pkg::PH_ERROR;
					end else begin
						nxt_class = hhfp_pkg::CL_KEY;
					end
				end
				hhfp_pkg::PH_KEYWS: begin
					if (entry.is_colon) begin
						nxt_phase = hhfp_pkg::PH_PREVAL;
					end else if (!entry.is_ws) begin
						nxt_phase = hhfp_pkg::PH_ERROR;
					end
				end
				hhfp_pkg::PH_PREVAL: begin
					if (!entry.is_ws) begin
						nxt_phase = hhfp_pkg::PH_VALUE;
						nxt_vc    = add_vc;
						nxt_tc    = add_tc;
						nxt_class = hhfp_pkg::CL_VALUE;
					end
				end
				hhfp_pkg::PH_VALUE: begin
					if (entry.is_cr) begin
						nxt_phase = hhfp_pkg::PH_VALLF;
					end else begin
						nxt_vc    = add_vc;
						nxt_tc    = add_tc;
						nxt_class = hhfp_pkg::CL_VALUE;
					end
				end
				hhfp_pkg::PH_VALLF: begin
					if (entry.is_lf) begin
						nxt_class = hhfp_pkg::CL_LINE;
						nxt_len   = hhfp_pkg::LEN_W'(cur_tc);
						nxt_vc    = '0;
						nxt_tc    = '0;
						nxt_phase = hhfp_pkg::PH_LINE;
					end else begin
						nxt_phase = hhfp_pkg::PH_ERROR;
					end
				end
				hhfp_pkg::PH_ENDLF: begin
					if (entry.is_lf) begin
						nxt_class = hhfp_pkg::CL_BLOCK;
						nxt_fin   = 1'b1;
					end else begin
						nxt_phase = hhfp_pkg::PH_ERROR;
					end
				end
				hhfp_pkg::PH_ERROR: begin
					nxt_phase = hhfp_pkg::PH_ERROR;
				end
			endcase
			// Errors override the tag; a final byte must leave the block complete.
			if (nxt_phase == hhfp_pkg::PH_ERROR) begin
				nxt_class = hhfp_pkg::CL_ERROR;
				nxt_len   = '0;
			end else if (entry.last_byte && !nxt_fin) begin
				nxt_phase = hhfp_pkg::PH_ERROR;
				nxt_class = hhfp_pkg::CL_ERROR;
				nxt_len   = '0;
			end
		end
	end

	// Parser state, updated once per item taken from the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= hhfp_pkg::PH_LINE;
			finished_q      <= 1'b0;
			value_count_q   <= '0;
			trimmed_count_q <= '0;
		end else if (pop) begin
			phase_q         <= nxt_phase;
			finished_q      <= nxt_fin;
			value_count_q   <= nxt_vc;
			trimmed_count_q <= nxt_tc;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (classified.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			out_class_q <= nxt_class;
			out_data_q  <= entry.data_byte;
			out_len_q   <= nxt_len;
		end
	end

	assign classified.valid        = out_valid_q;
	assign classified.byte_class   = out_class_q;
	assign classified.data_out     = out_data_q;
	assign classified.value_length = out_len_q;

endmodule

[rtl/http_header_field_parser.sv]
// HTTP header field parser: tags each header byte and reports trimmed value lengths.
// Path: an accepted byte is written into the queue, then popped into the output register and offered from there.
// Throughput: one byte per cycle while the output is not stalled; the back end updates its phase for each item.
// A four-entry queue lets input acceptance continue while the output is stalled, until the queue fills.
// Reset (arst_n low) empties the queue and output register and returns to line start.
module http_header_field_parser #(
	parameter int MAX_VALUE_LEN = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	hhfp_in_if.sink    raw,
	hhfp_out_if.source classified
);

	logic             push;
	logic             pop;
	logic             q_full;
	logic             q_avail;
	hhfp_pkg::entry_t push_entry;
	hhfp_pkg::entry_t pop_entry;

	// Byte acceptance and classification.
	hhfp_front u_front (
		.raw   (raw),
		.full  (q_full),
		.push  (push),
		.entry (push_entry)
	);

	// Decoupling queue.
	hhfp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.avail      (q_avail)
	);

	// Phase tracking and output register.
	hhfp_back #(
		.MAX_VALUE_LEN (MAX_VALUE_LEN)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.avail      (q_avail),
		.entry      (pop_entry),
		.pop        (pop),
		.classified (classified)
	);

endmodule

[rtl/hhfp_checker.sv]
// Port-level checks for the HTTP header field parser, bound to the top level.
// Watches both channels over time; depends on hhfp_pkg for the byte class codes.
module hhfp_checker #(
	parameter int MAX_VALUE_LEN = 4096
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [2:0]                  out_class,
	input logic [hhfp_pkg::DATA_W-1:0] out_data,
	input logic [hhfp_pkg::LEN_W-1:0]  out_len
);

	localparam int LEN_LIMIT = (1 << hhfp_pkg::LEN_W) - 1;

	// A stalled result holds still.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({out_class, out_data, out_len}))
		else $error("output item changed while stalled");

	// Only a line end carries a length.
	a_len_only_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_class != hhfp_pkg::CL_LINE) |-> (out_len == '0))
		else $error("nonzero length on an item that is not a line end");

	// The reported length never passes the saturation limit.
	a_len_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (MAX_VALUE_LEN > LEN_LIMIT) || (int'(out_len) <= MAX_VALUE_LEN))
		else $error("value length above the saturation limit");

	// Input backpressure only arises behind a held output item.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled while output register is empty");

endmodule

bind http_header_field_parser hhfp_checker #(
	.MAX_VALUE_LEN (MAX_VALUE_LEN)
) u_hhfp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (raw.ready),
	.out_valid (classified.valid),
	.out_ready (classified.ready),
	.out_class (classified.byte_class),
	.out_data  (classified.data_out),
	.out_len   (classified.value_length)
);
